// ===== rtl/float_tanh_rational_assert.svh =====
// Assertion macros used by the float tanh top level.
`ifndef FLOAT_TANH_RATIONAL_ASSERT_SVH
`define FLOAT_TANH_RATIONAL_ASSERT_SVH

// Checked on every clock edge outside reset.
`define FTR_ASSERT_ON(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FTR_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ftr_pkg.sv =====
// Shared types and constants of the float tanh pipeline.
`timescale 1ns / 1ps
`default_nettype none
package ftr_pkg;
   localparam int DATA_W   = 32;
   localparam int FRAC_CAP = 26;
   localparam int C_27     = 27;
   localparam int C_9      = 9;
   localparam int X_BIG    = 3;
   localparam int E_TINY   = -5;
   localparam int E_HUGE   = 2;

   // Result decided early, carried beside the arithmetic.
   typedef struct packed {
      logic              done;
      logic              sign;
      logic [DATA_W-1:0] res;
   } side_type;
endpackage
`default_nettype wire

// ===== rtl/ftr_unpack.sv =====
// Input stage: special cases and conversion of the magnitude to fixed point.
`timescale 1ns / 1ps
`default_nettype none
module ftr_unpack #(
   parameter int W  = 32,
   parameter int EW = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [31:0]               in_value,
   output logic                           out_valid,
   output logic [((W-EW-1+4) < 26 ? (W-EW-1+4) : 26)+1:0] out_x,
   output ftr_pkg::side_type              out_side
);
   import ftr_pkg::*;

   localparam int MANT = W - EW - 1;
   localparam int FRAC = (MANT + 4) < FRAC_CAP ? (MANT + 4) : FRAC_CAP;
   localparam int XW   = FRAC + 2;
   localparam int BIAS = (1 << (EW - 1)) - 1;

   logic              valid_ff;
   logic [XW-1:0]     x_ff;
   side_type          side_ff;
   logic [XW-1:0]     x_in;
   side_type          side_in;

   logic [W-1:0]      raw;
   logic              sign;
   logic [EW-1:0]     expo;
   logic [MANT-1:0]   mant;
   logic signed [EW+1:0] e;
   logic signed [5:0] sh;
   logic [3:0]        rsh;
   logic [MANT:0]     sig;
   logic [MANT:0]     q;
   logic [MANT:0]     rem;
   logic [MANT:0]     half;
   logic [XW:0]       xw;
   logic [DATA_W-1:0] one_bits;

   always_comb begin
      raw      = in_value[W-1:0];
      sign     = raw[W-1];
      expo     = raw[W-2:MANT];
      mant     = raw[MANT-1:0];
      e        = $signed({2'b00, expo}) - $signed((EW+2)'(BIAS));
      sh       = 6'(e) + 6'(FRAC - MANT);
      rsh      = 4'(-sh);
      sig      = {1'b1, mant};
      q        = sig >> rsh;
      rem      = sig & (((MANT+1)'(1) << rsh) - (MANT+1)'(1));
      half     = (MANT+1)'(1) << (rsh - 4'd1);
      one_bits = (DATA_W'(sign) << (W - 1)) | (DATA_W'(BIAS) << MANT);
      if (sh >= 0) begin
         xw = (XW+1)'(sig) << sh[2:0];
      end else if (rem > half || (rem == half && q[0])) begin
         xw = (XW+1)'(q) + (XW+1)'(1);
      end else begin
         xw = (XW+1)'(q);
      end
      x_in         = xw[XW-1:0];
      side_in.sign = sign;
      side_in.done = 1'b1;
      side_in.res  = one_bits;
      if (expo == '0) begin
         side_in.res = DATA_W'(sign) << (W - 1);
      end else if (expo == '1) begin
         if (mant != '0) begin
            side_in.res = (DATA_W'({EW{1'b1}}) << MANT) | DATA_W'(1);
         end
      end else if (e <= E_TINY) begin
         side_in.res = DATA_W'(raw);
      end else if (e >= E_HUGE) begin
         side_in.res = one_bits;
      end else if (xw >= (XW+1)'(X_BIG << FRAC)) begin
         side_in.res = one_bits;
      end else begin
         side_in.done = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         x_ff    <= x_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

// ===== rtl/ftr_poly.sv =====
// Polynomial stages: square, then numerator and denominator of the rational.
`timescale 1ns / 1ps
`default_nettype none
module ftr_poly #(
   parameter int W  = 32,
   parameter int EW = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [((W-EW-1+4) < 26 ? (W-EW-1+4) : 26)+1:0] in_x,
   input  wire ftr_pkg::side_type    in_side,
   output logic                      out_valid,
   output logic [2*((W-EW-1+4) < 26 ? (W-EW-1+4) : 26)+7:0] out_num,
   output logic [((W-EW-1+4) < 26 ? (W-EW-1+4) : 26)+6:0]   out_den,
   output ftr_pkg::side_type         out_side
);
   import ftr_pkg::*;

   localparam int MANT = W - EW - 1;
   localparam int FRAC = (MANT + 4) < FRAC_CAP ? (MANT + 4) : FRAC_CAP;
   localparam int XW   = FRAC + 2;
   localparam int X2W  = FRAC + 4;
   localparam int SW   = FRAC + 6;
   localparam int NUMW = XW + SW;
   localparam int DENW = FRAC + 7;

   logic              v1_ff;
   logic [XW-1:0]     x1_ff;
   logic [2*XW-1:0]   sq_ff;
   side_type          s1_ff;
   logic              v2_ff;
   logic [NUMW-1:0]   num_ff;
   logic [DENW-1:0]   den_ff;
   side_type          s2_ff;

   logic [2*XW-1:0]   sq_in;
   logic [X2W-1:0]    x2;
   logic [SW-1:0]     sum;
   logic [NUMW-1:0]   num_in;
   logic [DENW-1:0]   den_in;

   always_comb begin
      sq_in  = (2*XW)'(in_x) * (2*XW)'(in_x);
      x2     = X2W'(sq_ff >> FRAC);
      sum    = SW'(C_27 << FRAC) + SW'(x2);
      den_in = DENW'(C_27 << FRAC) + DENW'(x2) * DENW'(C_9);
      num_in = NUMW'(x1_ff) * NUMW'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         x1_ff  <= in_x;
         sq_ff  <= sq_in;
         s1_ff  <= in_side;
         num_ff <= num_in;
         den_ff <= den_in;
         s2_ff  <= s1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = s2_ff;
endmodule
`default_nettype wire

// ===== rtl/ftr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
`timescale 1ns / 1ps
`default_nettype none
module ftr_div #(
   parameter int W  = 32,
   parameter int EW = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [2*((W-EW-1+4) < 26 ? (W-EW-1+4) : 26)+7:0] in_num,
   input  wire logic [((W-EW-1+4) < 26 ? (W-EW-1+4) : 26)+6:0]   in_den,
   input  wire ftr_pkg::side_type in_side,
   output logic                   out_valid,
   output logic [((W-EW-1+4) < 26 ? (W-EW-1+4) : 26)+1:0] out_q,
   output ftr_pkg::side_type      out_side
);
   import ftr_pkg::*;

   localparam int MANT = W - EW - 1;
   localparam int FRAC = (MANT + 4) < FRAC_CAP ? (MANT + 4) : FRAC_CAP;
   localparam int QB   = FRAC + 2;
   localparam int NUMW = 2 * FRAC + 8;
   localparam int NW   = NUMW + 1;
   localparam int DENW = FRAC + 7;

   logic              valid_ff [QB];
   logic [NW-1:0]     rem_ff   [QB];
   logic [QB-1:0]     q_ff     [QB];
   logic [DENW-1:0]   den_ff   [QB];
   side_type          side_ff  [QB];

   logic              v_src    [QB];
   logic [NW-1:0]     r_src    [QB];
   logic [QB-1:0]     q_src    [QB];
   logic [DENW-1:0]   d_src    [QB];
   side_type          s_src    [QB];
   logic [NW-1:0]     rem_in   [QB];
   logic [QB-1:0]     q_in     [QB];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int B = QB - 1 - k;
      logic [NW-1:0] trial;
      logic          ge;

      if (k == 0) begin : g_first
         // Bias the dividend by half the divisor to round the quotient.
         assign v_src[k] = in_valid;
         assign r_src[k] = NW'(in_num) + NW'(in_den >> 1);
         assign q_src[k] = '0;
         assign d_src[k] = in_den;
         assign s_src[k] = in_side;
      end else begin : g_next
         assign v_src[k] = valid_ff[k-1];
         assign r_src[k] = rem_ff[k-1];
         assign q_src[k] = q_ff[k-1];
         assign d_src[k] = den_ff[k-1];
         assign s_src[k] = side_ff[k-1];
      end

      always_comb begin
         trial     = NW'(d_src[k]) << B;
         ge        = r_src[k] >= trial;
         rem_in[k] = ge ? r_src[k] - trial : r_src[k];
         q_in[k]   = q_src[k] | (QB'(ge) << B);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_src[k];
         end
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            den_ff[k]  <= d_src[k];
            side_ff[k] <= s_src[k];
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_q     = q_ff[QB-1];
   assign out_side  = side_ff[QB-1];
endmodule
`default_nettype wire

// ===== rtl/ftr_norm.sv =====
// Output stages: clamp, leading-one search, then rounding into float format.
`timescale 1ns / 1ps
`default_nettype none
module ftr_norm #(
   parameter int W  = 32,
   parameter int EW = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [((W-EW-1+4) < 26 ? (W-EW-1+4) : 26)+1:0] in_q,
   input  wire ftr_pkg::side_type in_side,
   output logic                   out_valid,
   output logic [31:0]            out_data
);
   import ftr_pkg::*;

   localparam int MANT = W - EW - 1;
   localparam int FRAC = (MANT + 4) < FRAC_CAP ? (MANT + 4) : FRAC_CAP;
   localparam int QB   = FRAC + 2;
   localparam int MSW  = $clog2(FRAC + 1);
   localparam int BIAS = (1 << (EW - 1)) - 1;
   localparam int RW   = (EW > 6 ? EW : 6) + 2;
   localparam int NMW  = MANT + 2;

   logic              v1_ff;
   logic [FRAC-1:0]   y_ff;
   logic [MSW-1:0]    msb_ff;
   side_type          s1_ff;
   logic              v2_ff;
   logic [DATA_W-1:0] data_ff;

   logic [QB-1:0]     y;
   logic [MSW-1:0]    msb_in;
   side_type          s1_in;
   logic [DATA_W-1:0] one_bits;
   logic signed [RW-1:0] rexp;
   logic              uflow;
   logic [FRAC-1:0]   yq;
   logic [FRAC-1:0]   yrem;
   logic [FRAC-1:0]   yhalf;
   logic [NMW-1:0]    norm;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      y        = (in_q > QB'(1 << FRAC)) ? QB'(1 << FRAC) : in_q;
      one_bits = (DATA_W'(in_side.sign) << (W - 1)) | (DATA_W'(BIAS) << MANT);
      s1_in    = in_side;
      msb_in   = '0;
      for (int i = 0; i < FRAC; i++) begin
         if (y[i]) begin
            msb_in = MSW'(i);
         end
      end
      if (!in_side.done) begin
         if (y == '0) begin
            s1_in.done = 1'b1;
            s1_in.res  = DATA_W'(in_side.sign) << (W - 1);
         end else if (y >= QB'(1 << FRAC)) begin
            s1_in.done = 1'b1;
            s1_in.res  = one_bits;
         end
      end
   end

   always_comb begin
      rexp  = $signed(RW'(msb_ff)) - $signed(RW'(FRAC)) + $signed(RW'(BIAS));
      // Underflow is judged on the exponent before any rounding carry.
      uflow = rexp <= 0;
      yq    = y_ff >> (msb_ff - MSW'(MANT));
      yrem  = y_ff & ((FRAC'(1) << (msb_ff - MSW'(MANT))) - FRAC'(1));
      yhalf = FRAC'(1) << (msb_ff - MSW'(MANT) - MSW'(1));
      if (msb_ff > MSW'(MANT)) begin
         if (yrem > yhalf || (yrem == yhalf && yq[0])) begin
            norm = NMW'(yq) + NMW'(1);
         end else begin
            norm = NMW'(yq);
         end
      end else begin
         norm = NMW'(y_ff) << (MANT - msb_ff);
      end
      // Rounding carried out of the mantissa: renormalize.
      if (norm[MANT+1]) begin
         norm = norm >> 1;
         rexp = rexp + RW'(1);
      end
      if (s1_ff.done) begin
         data_in = s1_ff.res;
      end else if (uflow) begin
         data_in = DATA_W'(s1_ff.sign) << (W - 1);
      end else begin
         data_in = (DATA_W'(s1_ff.sign) << (W - 1))
                 | (DATA_W'(rexp[EW-1:0]) << MANT)
                 | DATA_W'(norm[MANT-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         y_ff    <= y[FRAC-1:0];
         msb_ff  <= msb_in;
         s1_ff   <= s1_in;
         data_ff <= data_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// ===== rtl/float_tanh_rational.sv =====
// Top level of the pipelined float tanh unit.
`timescale 1ns / 1ps
`default_nettype none
`include "float_tanh_rational_assert.svh"
// Pipelined tanh of a TOTAL_WIDTH-bit float (sign, EXP_BITS exponent bits,
// mantissa). One word enters per cycle while no result is stalled at the
// output. Here FRAC = min(mantissa bits + 4, 26); most of the stages belong
// to the restoring divider, which resolves one quotient bit per stage for
// FRAC + 2 stages. The whole pipeline advances whenever the output
// register is empty or being taken, so a stalled result holds every stage.
module float_tanh_rational #(
   parameter int TOTAL_WIDTH = 32,
   parameter int EXP_BITS    = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [31:0] tanh_out
);
   import ftr_pkg::*;

   localparam int MANT = TOTAL_WIDTH - EXP_BITS - 1;
   localparam int FRAC = (MANT + 4) < FRAC_CAP ? (MANT + 4) : FRAC_CAP;
   localparam logic [31:0] EXP_FIELD = ((32'd1 << EXP_BITS) - 32'd1) << MANT;
   localparam logic [31:0] NAN_BITS  = EXP_FIELD | 32'd1;

   logic                  en;
   logic                  u_valid;
   logic [FRAC+1:0]       u_x;
   side_type              u_side;
   logic                  p_valid;
   logic [2*FRAC+7:0]     p_num;
   logic [FRAC+6:0]       p_den;
   side_type              p_side;
   logic                  d_valid;
   logic [FRAC+1:0]       d_q;
   side_type              d_side;
   logic [31:0]           rsp_upper;
   logic                  nan_bad;

   // Advance everything unless a finished word is stuck at the output.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   ftr_unpack #(.W(TOTAL_WIDTH), .EW(EXP_BITS)) u_unpack (
      .clock, .reset, .en,
      .in_valid (req_tvalid), .in_value (req_tdata),
      .out_valid(u_valid), .out_x(u_x), .out_side(u_side)
   );

   ftr_poly #(.W(TOTAL_WIDTH), .EW(EXP_BITS)) u_poly (
      .clock, .reset, .en,
      .in_valid (u_valid), .in_x(u_x), .in_side(u_side),
      .out_valid(p_valid), .out_num(p_num), .out_den(p_den), .out_side(p_side)
   );

   ftr_div #(.W(TOTAL_WIDTH), .EW(EXP_BITS)) u_div (
      .clock, .reset, .en,
      .in_valid (p_valid), .in_num(p_num), .in_den(p_den), .in_side(p_side),
      .out_valid(d_valid), .out_q(d_q), .out_side(d_side)
   );

   ftr_norm #(.W(TOTAL_WIDTH), .EW(EXP_BITS)) u_norm (
      .clock, .reset, .en,
      .in_valid (d_valid), .in_q(d_q), .in_side(d_side),
      .out_valid(rsp_tvalid), .out_data(rsp_tdata)
   );

   assign rsp_upper = (rsp_tdata >> (TOTAL_WIDTH - 1)) >> 1;
   assign nan_bad   = ((rsp_tdata & EXP_FIELD) == EXP_FIELD) && (rsp_tdata != NAN_BITS);

   `FTR_ASSERT_ALL(a_reset_empty, clock, reset |=> !rsp_tvalid, "output valid after reset")
   `FTR_ASSERT_ON(a_stall_cause, clock, reset, !req_tready |-> rsp_tvalid, "stall, output empty")
   `FTR_ASSERT_ON(a_upper_zero, clock, reset, rsp_tvalid |-> rsp_upper == '0, "bits above width")
   `FTR_ASSERT_ON(a_nan_canon, clock, reset, rsp_tvalid |-> !nan_bad, "non-canonical NaN")
endmodule
`default_nettype wire

// ===== tb/sv/float_tanh_rational_tb.sv =====
// Testbench for the float tanh unit: directed table plus random floats against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module float_tanh_rational_tb;
   localparam int TOTAL_W  = 32;
   localparam int EXP_W    = 8;
   localparam int MANT_W   = TOTAL_W - EXP_W - 1;
   localparam int FRAC_W   = (MANT_W + 4) < ftr_pkg::FRAC_CAP ? (MANT_W + 4) : ftr_pkg::FRAC_CAP;
   localparam int BIAS     = (1 << (EXP_W - 1)) - 1;
   localparam int LATENCY  = FRAC_W + 7;
   localparam int N_RANDOM = 930;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   logic [31:0] tanh_expected[$];
   int          n_errors = 0;
   int          n_checked = 0;
   longint      cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_rsp = 1'b0;

   float_tanh_rational #(.TOTAL_WIDTH(TOTAL_W), .EXP_BITS(EXP_W)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] round_shift(logic [63:0] v, int sh);
      logic [63:0] q, rem, half;
      q = v >> sh;
      rem = v & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      return q;
   endfunction

   function automatic logic [31:0] predict_tanh(logic [31:0] raw);
      logic [63:0] sgn, expo, mant, one_bits, one_fx, sig, x, x2, num, den, y, norm;
      int e, sh, msb, rexp;
      sgn = raw[TOTAL_W-1] ? (64'd1 << (TOTAL_W - 1)) : 64'd0;
      expo = (raw >> MANT_W) & ((64'd1 << EXP_W) - 1);
      mant = raw & ((64'd1 << MANT_W) - 1);
      one_bits = sgn | (64'(BIAS) << MANT_W);
      one_fx = 64'd1 << FRAC_W;
      if (expo == 0) return sgn[31:0];
      if (expo == (64'd1 << EXP_W) - 1)
         return (mant != 0) ? 32'((((64'd1 << EXP_W) - 1) << MANT_W) | 64'd1) : one_bits[31:0];
      e = int'(expo) - BIAS;
      if (e <= ftr_pkg::E_TINY) return raw;
      if (e >= ftr_pkg::E_HUGE) return one_bits[31:0];
      sig = (64'd1 << MANT_W) | mant;
      sh = FRAC_W + e - MANT_W;
      x = (sh >= 0) ? (sig << sh) : round_shift(sig, -sh);
      if (x >= ftr_pkg::X_BIG * one_fx) begin
         y = one_fx;
      end else begin
         x2 = (x * x) >> FRAC_W;
         num = x * (ftr_pkg::C_27 * one_fx + x2);
         den = ftr_pkg::C_27 * one_fx + ftr_pkg::C_9 * x2;
         y = (num + den / 2) / den;
         if (y > one_fx) y = one_fx;
      end
      if (y == 0) return sgn[31:0];
      if (y >= one_fx) return one_bits[31:0];
      msb = 0;
      for (int i = 0; i < 32; i++) if ((y >> i) != 0) msb = i;
      rexp = msb - FRAC_W + BIAS;
      if (rexp <= 0) return sgn[31:0];
      norm = (msb > MANT_W) ? round_shift(y, msb - MANT_W) : (y << (MANT_W - msb));
      if (norm >= (64'd1 << (MANT_W + 1))) begin
         norm = norm >> 1;
         rexp++;
      end
      return 32'(sgn | (64'(rexp) << MANT_W) | (norm & ((64'd1 << MANT_W) - 1)));
   endfunction

   task automatic report_mismatch(input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at cycle %0d: tanh_out got %h want %h", cycle_count, got, want);
      n_errors++;
   endtask

   // Offer one word, then wait for the handshake; drop valid only while idling.
   task automatic send_word(input logic [31:0] value, input logic [31:0] want, input bit typed);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      tanh_expected.push_back(typed ? want : predict_tanh(value));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] random_float();
      logic [31:0] v;
      int pick;
      v = $urandom();
      pick = $urandom_range(9, 0);
      // Most words land in the computed range, unbiased exponent -4 to 1.
      if (pick < 7) v[30:23] = 8'(BIAS - 4 + $urandom_range(5, 0));
      else if (pick == 7) v[30:23] = $urandom_range(1, 0) ? 8'hFF : 8'h00;
      return v;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout");
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tanh_expected.size() == 0) begin
            report_mismatch(rsp_tdata, 'x);
         end else begin
            if (rsp_tdata !== tanh_expected[0]) report_mismatch(rsp_tdata, tanh_expected[0]);
            void'(tanh_expected.pop_front());
            n_checked++;
         end
      end
      rsp_tready <= !hold_rsp && !(recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct);
   end

   typedef struct {
      logic [31:0] value;
      logic [31:0] want;
      bit          typed;
   } stim_row_type;

   stim_row_type directed[] = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1},
      '{32'h8000_0000, 32'h8000_0000, 1'b1},
      '{32'h007F_FFFF, 32'h0000_0000, 1'b1},
      '{32'h8000_0001, 32'h8000_0000, 1'b1},
      '{32'h7FC0_0000, 32'h7F80_0001, 1'b1},
      '{32'hFFFF_FFFF, 32'h7F80_0001, 1'b1},
      '{32'h7F80_0000, 32'h3F80_0000, 1'b1},
      '{32'hFF80_0000, 32'hBF80_0000, 1'b1},
      '{32'h3D7F_FFFF, 32'h3D7F_FFFF, 1'b1},
      '{32'h0080_0000, 32'h0080_0000, 1'b1},
      '{32'h4080_0000, 32'h3F80_0000, 1'b1},
      '{32'hFF7F_FFFF, 32'hBF80_0000, 1'b1},
      '{32'h3D80_0000, 32'h0, 1'b0},
      '{32'hBD80_0000, 32'h0, 1'b0},
      '{32'h3F80_0000, 32'h0, 1'b0},
      '{32'hBF00_0000, 32'h0, 1'b0},
      '{32'h3FFF_FFFF, 32'h0, 1'b0},
      '{32'h3FC0_0000, 32'h0, 1'b0},
      '{32'h3E80_0001, 32'h0, 1'b0},
      '{32'hBF55_5555, 32'h0, 1'b0}
   };

   // Hold off the receiver long enough that the pipeline fills and back-pressures.
   task automatic long_stall();
      hold_rsp = 1'b1;
      repeat (3 * LATENCY) @(posedge clock);
      hold_rsp = 1'b0;
   endtask

   task automatic drain();
      while (tanh_expected.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_word(directed[i].value, directed[i].want, directed[i].typed);
      req_tvalid <= 1'b0;
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 63 : 0;
         recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 29 : 0;
         fork
            if (phase == 2) long_stall();
            for (int n = 0; n < N_RANDOM / 3; n++) send_word(random_float(), '0, 1'b0);
         join
         req_tvalid <= 1'b0;
         drain();
      end
      repeat (LATENCY + 5) @(posedge clock);
      $display("checked %0d results: zeros, subnormals, NaN, infinities, tiny and large", n_checked);
      $display("exponents, and random floats under sender and receiver stalls");
      if (n_errors == 0 && tanh_expected.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/ftr_pkg.sv
rtl/ftr_unpack.sv
rtl/ftr_poly.sv
rtl/ftr_div.sv
rtl/ftr_norm.sv
rtl/float_tanh_rational.sv
tb/sv/float_tanh_rational_tb.sv
